// File: rtl/core/cua_pkg.sv
// Package for the CPU utilisation averager: widths, constants, controller
// states and the command/status structs between controller and datapath.
// No dependencies.
`default_nettype none

package cua_pkg;

    localparam int TICK_W     = 64;
    localparam int USAGE_W    = 17;
    localparam int FRAC_BITS  = 16;
    localparam int WINDOW_DEF = 5;

    localparam logic [USAGE_W-1:0] ONE_Q16 = 17'h10000;

    typedef enum logic [3:0] {
        S_IDLE,
        S_BUSY1,
        S_BUSY2,
        S_TOTAL,
        S_DIV_LD,
        S_DIV,
        S_USAGE,
        S_FILL_LD,
        S_FILL,
        S_FILL_END,
        S_RING_RD,
        S_RING_UPD,
        S_AVG_LD,
        S_AVG_ST,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load_in;
        logic add_ns;
        logic add_sys;
        logic add_idle;
        logic div_usage_ld;
        logic div_step;
        logic usage_st;
        logic fill_start;
        logic fill_wr;
        logic fill_end;
        logic ring_rd;
        logic ring_upd;
        logic avg_ld;
        logic avg_st;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic primed;
        logic filled;
        logic div_last;
        logic fill_last;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

// File: rtl/core/cua_if.sv
// Valid/ready channel interfaces for snapshot input and usage result output.
// Depends on cua_pkg.
`default_nettype none

interface cua_in_if;
    logic                         valid;
    logic                         ready;
    logic [cua_pkg::TICK_W-1:0]   user_ticks;
    logic [cua_pkg::TICK_W-1:0]   nice_ticks;
    logic [cua_pkg::TICK_W-1:0]   system_ticks;
    logic [cua_pkg::TICK_W-1:0]   idle_ticks;

    modport source (
        output valid, user_ticks, nice_ticks, system_ticks, idle_ticks,
        input  ready
    );
    modport sink (
        input  valid, user_ticks, nice_ticks, system_ticks, idle_ticks,
        output ready
    );
endinterface

interface cua_out_if;
    logic                         valid;
    logic                         ready;
    logic                         sample_valid;
    logic [cua_pkg::USAGE_W-1:0]  last_usage;
    logic [cua_pkg::USAGE_W-1:0]  recent_average;

    modport source (
        output valid, sample_valid, last_usage, recent_average,
        input  ready
    );
    modport sink (
        input  valid, sample_valid, last_usage, recent_average,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/core/cua_ctrl.sv
// Controller state machine sequencing one snapshot through the datapath.
// Depends on cua_pkg.
`default_nettype none

module cua_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire cua_pkg::t_sts i_sts,
    output logic               o_in_ready,
    output cua_pkg::t_cmd      o_cmd
);

    cua_pkg::t_state r_state;
    cua_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cua_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            cua_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_sts.primed ? cua_pkg::S_BUSY1 : cua_pkg::S_DONE;
                end
            end
            cua_pkg::S_BUSY1:    n_state = cua_pkg::S_BUSY2;
            cua_pkg::S_BUSY2:    n_state = cua_pkg::S_TOTAL;
            cua_pkg::S_TOTAL:    n_state = cua_pkg::S_DIV_LD;
            cua_pkg::S_DIV_LD:   n_state = cua_pkg::S_DIV;
            cua_pkg::S_DIV: begin
                if (i_sts.div_last) begin
                    n_state = cua_pkg::S_USAGE;
                end
            end
            cua_pkg::S_USAGE: begin
                n_state = i_sts.filled ? cua_pkg::S_RING_RD : cua_pkg::S_FILL_LD;
            end
            cua_pkg::S_FILL_LD:  n_state = cua_pkg::S_FILL;
            cua_pkg::S_FILL: begin
                if (i_sts.fill_last) begin
                    n_state = cua_pkg::S_FILL_END;
                end
            end
            cua_pkg::S_FILL_END: n_state = cua_pkg::S_AVG_LD;
            cua_pkg::S_RING_RD:  n_state = cua_pkg::S_RING_UPD;
            cua_pkg::S_RING_UPD: n_state = cua_pkg::S_AVG_LD;
            cua_pkg::S_AVG_LD:   n_state = cua_pkg::S_AVG_ST;
            cua_pkg::S_AVG_ST:   n_state = cua_pkg::S_DONE;
            cua_pkg::S_DONE: begin
                if (i_sts.out_free) begin
                    n_state = cua_pkg::S_IDLE;
                end
            end
            default:             n_state = cua_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            cua_pkg::S_IDLE: begin
                o_in_ready    = i_rst_n;
                o_cmd.load_in = i_in_valid && i_rst_n;
            end
            cua_pkg::S_BUSY1:    o_cmd.add_ns       = 1'b1;
            cua_pkg::S_BUSY2:    o_cmd.add_sys      = 1'b1;
            cua_pkg::S_TOTAL:    o_cmd.add_idle     = 1'b1;
            cua_pkg::S_DIV_LD:   o_cmd.div_usage_ld = 1'b1;
            cua_pkg::S_DIV:      o_cmd.div_step     = 1'b1;
            cua_pkg::S_USAGE:    o_cmd.usage_st     = 1'b1;
            cua_pkg::S_FILL_LD:  o_cmd.fill_start   = 1'b1;
            cua_pkg::S_FILL:     o_cmd.fill_wr      = 1'b1;
            cua_pkg::S_FILL_END: o_cmd.fill_end     = 1'b1;
            cua_pkg::S_RING_RD:  o_cmd.ring_rd      = 1'b1;
            cua_pkg::S_RING_UPD: o_cmd.ring_upd     = 1'b1;
            cua_pkg::S_AVG_LD:   o_cmd.avg_ld       = 1'b1;
            cua_pkg::S_AVG_ST:   o_cmd.avg_st       = 1'b1;
            cua_pkg::S_DONE:     o_cmd.out_load     = i_sts.out_free;
            default: begin
                o_cmd      = '0;
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/core/cua_datapath.sv
// Datapath: tick deltas, serial restoring divider for the usage, reciprocal
// multiply for the mean, usage ring memory, running sum and output register.
// Depends on cua_pkg.
`default_nettype none

module cua_datapath #(
    parameter int WINDOW = cua_pkg::WINDOW_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire cua_pkg::t_cmd                 i_cmd,
    output cua_pkg::t_sts                      o_sts,
    input  wire logic [cua_pkg::TICK_W-1:0]    i_user_ticks,
    input  wire logic [cua_pkg::TICK_W-1:0]    i_nice_ticks,
    input  wire logic [cua_pkg::TICK_W-1:0]    i_system_ticks,
    input  wire logic [cua_pkg::TICK_W-1:0]    i_idle_ticks,
    input  wire logic                          i_out_ready,
    output logic                               o_out_valid,
    output logic                               o_sample_valid,
    output logic [cua_pkg::USAGE_W-1:0]        o_last_usage,
    output logic [cua_pkg::USAGE_W-1:0]        o_recent_average
);

    localparam int TW     = cua_pkg::TICK_W;
    localparam int UW     = cua_pkg::USAGE_W;
    localparam int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SUM_W  = $clog2(WINDOW) + UW;
    localparam int STEP_W = $clog2(SUM_W + 1);

    localparam int     AVG_SH  = SUM_W + $clog2(WINDOW);
    localparam int     RCP_W   = AVG_SH + 1;
    localparam int     PROD_W  = SUM_W + RCP_W;
    localparam longint RCP_VAL = ((longint'(1) << AVG_SH) + longint'(WINDOW) - 1)
                                 / longint'(WINDOW);
    localparam logic [RCP_W-1:0] RCP = RCP_W'(RCP_VAL);

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW - 1);

    logic [TW-1:0]     r_prev_user, r_prev_nice, r_prev_system, r_prev_idle;
    logic [TW-1:0]     r_du, r_dn, r_ds, r_di;
    logic [TW-1:0]     r_busy, r_total;
    logic [TW-1:0]     r_rem, r_den;
    logic [SUM_W-1:0]  r_quo;
    logic [STEP_W-1:0] r_step, r_div_len;
    logic              r_spec;
    logic [UW-1:0]     r_spec_val;
    logic [UW-1:0]     r_usage;
    logic [UW-1:0]     r_avg;
    logic [UW-1:0]     r_ring [WINDOW];
    logic [UW-1:0]     r_rd_data;
    logic [IDX_W-1:0]  r_fill_idx;
    logic [IDX_W-1:0]  r_idx;
    logic [SUM_W-1:0]  r_sum;
    logic              r_primed, r_filled, r_sample;
    logic [UW-1:0]     r_latest_usage, r_latest_avg;
    logic              r_out_valid;
    logic              r_out_sample;
    logic [UW-1:0]     r_out_usage, r_out_avg;

    logic [TW:0]       rem_sh;
    logic              take;
    logic [TW:0]       rem_sub;
    logic [IDX_W-1:0]  idx_next;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [PROD_W-1:0] avg_prod;

    assign rem_sh   = {r_rem, r_quo[SUM_W-1]};
    assign rem_sub  = rem_sh - {1'b0, r_den};
    assign take     = !rem_sub[TW];
    assign idx_next = (r_idx == IDX_LAST) ? '0 : r_idx + 1'b1;
    assign wr_en    = i_cmd.fill_wr || i_cmd.ring_upd;
    assign wr_addr  = i_cmd.fill_wr ? r_fill_idx : r_idx;
    assign avg_prod = PROD_W'(r_sum) * PROD_W'(RCP);

    // deltas and busy/total
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_du          <= i_user_ticks   - r_prev_user;
            r_dn          <= i_nice_ticks   - r_prev_nice;
            r_ds          <= i_system_ticks - r_prev_system;
            r_di          <= i_idle_ticks   - r_prev_idle;
            r_prev_user   <= i_user_ticks;
            r_prev_nice   <= i_nice_ticks;
            r_prev_system <= i_system_ticks;
            r_prev_idle   <= i_idle_ticks;
        end
        if (i_cmd.add_ns) begin
            r_busy <= r_du + r_dn;
        end
        if (i_cmd.add_sys) begin
            r_busy <= r_busy + r_ds;
        end
        if (i_cmd.add_idle) begin
            r_total <= r_busy + r_di;
        end
    end

    // restoring divider for the usage fraction
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_usage_ld) begin
            r_rem      <= r_busy;
            r_den      <= r_total;
            r_quo      <= '0;
            r_step     <= '0;
            r_div_len  <= STEP_W'(cua_pkg::FRAC_BITS);
            r_spec     <= (r_total == '0) || (r_busy >= r_total);
            r_spec_val <= (r_total == '0) ? '0 : cua_pkg::ONE_Q16;
        end else if (i_cmd.div_step) begin
            r_rem  <= take ? rem_sub[TW-1:0] : rem_sh[TW-1:0];
            r_quo  <= {r_quo[SUM_W-2:0], take};
            r_step <= r_step + 1'b1;
        end
        if (i_cmd.usage_st) begin
            r_usage <= r_spec ? r_spec_val : r_quo[UW-1:0];
        end
        if (i_cmd.avg_ld) begin
            r_avg <= avg_prod[AVG_SH +: UW];
        end
    end

    // usage ring
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_ring[wr_addr] <= r_usage;
        end
        if (i_cmd.ring_rd) begin
            r_rd_data <= r_ring[idx_next];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fill_start) begin
            r_fill_idx <= '0;
        end else if (i_cmd.fill_wr) begin
            r_fill_idx <= r_fill_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_primed       <= 1'b0;
            r_filled       <= 1'b0;
            r_sample       <= 1'b0;
            r_idx          <= '0;
            r_sum          <= '0;
            r_latest_usage <= '0;
            r_latest_avg   <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cmd.load_in) begin
                r_sample <= r_primed;
                r_primed <= 1'b1;
            end
            if (i_cmd.fill_start) begin
                r_sum <= '0;
            end else if (i_cmd.fill_wr) begin
                r_sum <= r_sum + SUM_W'(r_usage);
            end else if (i_cmd.ring_upd) begin
                r_sum <= r_sum - SUM_W'(r_rd_data) + SUM_W'(r_usage);
            end
            if (i_cmd.fill_end) begin
                r_filled <= 1'b1;
                r_idx    <= idx_next;
            end else if (i_cmd.ring_rd) begin
                r_idx <= idx_next;
            end
            if (i_cmd.avg_st) begin
                r_latest_usage <= r_usage;
                r_latest_avg   <= r_avg;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_sample <= r_sample;
            r_out_usage  <= r_latest_usage;
            r_out_avg    <= r_latest_avg;
        end
    end

    assign o_sts.primed    = r_primed;
    assign o_sts.filled    = r_filled;
    assign o_sts.div_last  = (r_step == r_div_len - 1'b1);
    assign o_sts.fill_last = (r_fill_idx == IDX_LAST);
    assign o_sts.out_free  = !r_out_valid;

    assign o_out_valid      = r_out_valid;
    assign o_sample_valid   = r_out_sample;
    assign o_last_usage     = r_out_usage;
    assign o_recent_average = r_out_avg;

endmodule

`default_nettype wire

// File: rtl/core/cpu_utilization_averager.sv
// A priming item only sets the baseline; its result has sample_valid low. A later
// item runs the deltas, usage divider and average; the first sample fills the ring.
// One item at a time, the 16-step serial usage divider setting the pace; a result
// waits while the output register is full, and it is held while the next snapshot
// is taken. Synchronous active-low reset clears the status flags, ring index, sum
// and latest results; the tick baseline and ring contents are not reset.
`default_nettype none

module cpu_utilization_averager #(
    parameter int WINDOW = cua_pkg::WINDOW_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    cua_in_if.sink     i_in,
    cua_out_if.source  o_out
);

    cua_pkg::t_cmd cmd;
    cua_pkg::t_sts sts;
    logic          in_ready;

    cua_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_sts      (sts),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    cua_datapath #(
        .WINDOW (WINDOW)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_user_ticks     (i_in.user_ticks),
        .i_nice_ticks     (i_in.nice_ticks),
        .i_system_ticks   (i_in.system_ticks),
        .i_idle_ticks     (i_in.idle_ticks),
        .i_out_ready      (o_out.ready),
        .o_out_valid      (o_out.valid),
        .o_sample_valid   (o_out.sample_valid),
        .o_last_usage     (o_out.last_usage),
        .o_recent_average (o_out.recent_average)
    );

    assign i_in.ready = in_ready;

endmodule

`default_nettype wire
